>>> rtl/thc_pkg.sv
package thc_pkg;

  localparam int TEMP_W = 8;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_BUTTON = 2'd1,
    MODE_LOAD   = 2'd2
  } mode_t;

  localparam logic [2:0] BTN_POWER  = 3'd1;
  localparam logic [2:0] BTN_TARGET = 3'd2;
  localparam logic [2:0] BTN_PLUS   = 3'd3;
  localparam logic [2:0] BTN_MINUS  = 3'd4;

  localparam logic [1:0] HEAT_OFF  = 2'd0;
  localparam logic [1:0] HEAT_HALF = 2'd1;
  localparam logic [1:0] HEAT_FULL = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_MISSING = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam logic [2:0] SAVE_NONE   = 3'd0;
  localparam logic [2:0] SAVE_NORMAL = 3'd1;
  localparam logic [2:0] SAVE_MAX    = 3'd2;
  localparam logic [2:0] SAVE_TARGET = 3'd3;
  localparam logic [2:0] SAVE_POWER  = 3'd4;

  localparam logic [2:0] REG_TEMP_LOW       = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH      = 3'd1;
  localparam logic [2:0] REG_HYSTERESIS     = 3'd2;
  localparam logic [2:0] REG_DEFAULT_NORMAL = 3'd3;
  localparam logic [2:0] REG_DEFAULT_MAX    = 3'd4;

  localparam logic [TEMP_W-1:0] RST_TEMP_LOW       = 8'd5;
  localparam logic [TEMP_W-1:0] RST_TEMP_HIGH      = 8'd95;
  localparam logic [TEMP_W-1:0] RST_HYSTERESIS     = 8'd2;
  localparam logic [TEMP_W-1:0] RST_DEFAULT_NORMAL = 8'd25;
  localparam logic [TEMP_W-1:0] RST_DEFAULT_MAX    = 8'd60;

  localparam logic [7:0] STORED_POWER_FULL = 8'd2;
  localparam logic [7:0] STORED_TARGET_MAX = 8'd1;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_low;
    logic [TEMP_W-1:0] temp_high;
    logic [TEMP_W-1:0] hysteresis;
    logic [TEMP_W-1:0] default_normal;
    logic [TEMP_W-1:0] default_max;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] normal_setpoint;
    logic [TEMP_W-1:0] max_setpoint;
    logic              target_is_max;
    logic              power_full;
    logic [1:0]        heater_cmd;
    logic              warm_lamp;
    logic              show_measured_next;
  } state_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        button;
    logic [TEMP_W-1:0] measured;
    logic              sensor_present;
    logic [TEMP_W-1:0] stored_normal;
    logic [TEMP_W-1:0] stored_max;
    logic [7:0]        stored_power;
    logic [7:0]        stored_target;
  } item_t;

  typedef struct packed {
    logic [1:0] heater_drive;
    logic       warm_led;
    logic       led_normal;
    logic       led_max;
    logic       led_full;
    logic [1:0] error_code;
    logic       show_update;
    logic [4:0] digit_tens;
    logic [3:0] digit_ones;
    logic [2:0] save_request;
  } result_t;

  function automatic logic in_range(input logic [TEMP_W-1:0] v,
                                    input logic [TEMP_W-1:0] lo,
                                    input logic [TEMP_W-1:0] hi);
    in_range = (v >= lo) && (v <= hi);
  endfunction

endpackage

>>> rtl/thermostat_hysteresis_controller_unit.sv
// Thermostat event processor: one event beat (sample, button or load) is taken
// per clock while s_tready is high and yields one result beat, through an input
// register and a result register with all decision logic between them. The
// sustained rate is one event per cycle unless the output stalls; the input
// register absorbs one beat while a result waits to be taken, then s_tready drops.
// Configuration writes on cfg_we take effect at once and are expected only
// while no event is in flight.
module thermostat_hysteresis_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // button, measured, sensor_present, stored_normal, stored_max,
  // stored_power, stored_target
  input  logic [47:0] s_tdata,
  // mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // heater_drive, warm_led, led_normal, led_max, led_full, error_code,
  // show_update, digit_tens, digit_ones, save_request
  output logic [23:0] m_tdata
);
  import thc_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  item_t   item_in;
  logic    item_valid;
  logic    advance;
  result_t res_next;
  result_t res;

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  assign item_in.mode           = mode_t'(s_tuser);
  assign item_in.button         = s_tdata[2:0];
  assign item_in.measured       = s_tdata[10:3];
  assign item_in.sensor_present = s_tdata[11];
  assign item_in.stored_normal  = s_tdata[19:12];
  assign item_in.stored_max     = s_tdata[27:20];
  assign item_in.stored_power   = s_tdata[35:28];
  assign item_in.stored_target  = s_tdata[43:36];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_low       <= RST_TEMP_LOW;
      cfg.temp_high      <= RST_TEMP_HIGH;
      cfg.hysteresis     <= RST_HYSTERESIS;
      cfg.default_normal <= RST_DEFAULT_NORMAL;
      cfg.default_max    <= RST_DEFAULT_MAX;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEMP_LOW:       cfg.temp_low       <= cfg_wdata;
        REG_TEMP_HIGH:      cfg.temp_high      <= cfg_wdata;
        REG_HYSTERESIS:     cfg.hysteresis     <= cfg_wdata;
        REG_DEFAULT_NORMAL: cfg.default_normal <= cfg_wdata;
        REG_DEFAULT_MAX:    cfg.default_max    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_in;
    end
  end

  thc_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.normal_setpoint    <= RST_DEFAULT_NORMAL;
      st.max_setpoint       <= RST_DEFAULT_MAX;
      st.target_is_max      <= 1'b0;
      st.power_full         <= 1'b0;
      st.heater_cmd         <= HEAT_OFF;
      st.warm_lamp          <= 1'b0;
      st.show_measured_next <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'd0, res.save_request, res.digit_ones, res.digit_tens,
                    res.show_update, res.error_code, res.led_full, res.led_max,
                    res.led_normal, res.warm_led, res.heater_drive};

  // an error beat always reports the heater off
  a_err_heater_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.error_code != ERR_NONE) |-> res.heater_drive == HEAT_OFF)
    else $error("heater on with error");

  // exactly one setpoint mode lamp
  a_mode_leds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.led_normal != res.led_max)
    else $error("mode lamps inconsistent");

  // digits blank unless updated, and decimal when updated
  a_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.show_update || (res.digit_tens == 5'd0 && res.digit_ones == 4'd0))
                 && res.digit_ones <= 4'd9)
    else $error("bad display digits");

  // setpoint state advances only when an event is consumed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(st))
    else $error("state changed without event");

endmodule

>>> rtl/thc_eval.sv
module thc_eval (
  input  thc_pkg::cfg_t    cfg,
  input  thc_pkg::state_t  st,
  input  thc_pkg::item_t   item,
  output thc_pkg::state_t  st_next,
  output thc_pkg::result_t res
);
  import thc_pkg::*;

  logic [TEMP_W-1:0] check;
  logic [TEMP_W-1:0] reading;
  logic [TEMP_W-1:0] stepped;
  logic [TEMP_W-1:0] shown;
  logic              update;
  logic [1:0]        err;
  logic [2:0]        save;
  logic signed [TEMP_W+1:0] on_level;
  logic signed [TEMP_W+1:0] reading_s;
  logic [TEMP_W+7:0] tens_prod;
  logic [4:0]        tens;
  logic [TEMP_W-1:0] tens_x10;

  assign check     = st.target_is_max ? st.max_setpoint : st.normal_setpoint;
  assign reading   = item.sensor_present ? item.measured : '0;
  assign on_level  = $signed({2'b00, check}) - $signed({2'b00, cfg.hysteresis});
  assign reading_s = $signed({2'b00, reading});
  assign stepped   = (item.button == BTN_PLUS) ? check + 8'd1 : check - 8'd1;

  always_comb begin
    st_next = st;
    update  = 1'b0;
    err     = ERR_NONE;
    save    = SAVE_NONE;
    shown   = '0;
    case (item.mode)
      MODE_SAMPLE: begin
        if (!item.sensor_present) begin
          st_next.heater_cmd = HEAT_OFF;
          err = ERR_MISSING;
        end else if (!in_range(reading, cfg.temp_low, cfg.temp_high)) begin
          st_next.heater_cmd = HEAT_OFF;
          err = ERR_RANGE;
        end else if (reading_s <= on_level) begin
          st_next.heater_cmd = st.power_full ? HEAT_FULL : HEAT_HALF;
          st_next.warm_lamp  = 1'b1;
        end else if (reading >= check) begin
          st_next.heater_cmd = HEAT_OFF;
          st_next.warm_lamp  = 1'b0;
        end
        update = 1'b1;
        shown  = st.show_measured_next ? reading : check;
        st_next.show_measured_next = !st.show_measured_next;
      end
      MODE_BUTTON: begin
        case (item.button)
          BTN_POWER: begin
            st_next.power_full = !st.power_full;
            save = SAVE_POWER;
          end
          BTN_TARGET: begin
            st_next.target_is_max      = !st.target_is_max;
            st_next.show_measured_next = 1'b0;
            update = 1'b1;
            shown  = st.target_is_max ? st.normal_setpoint : st.max_setpoint;
            save   = SAVE_TARGET;
          end
          BTN_PLUS, BTN_MINUS: begin
            st_next.show_measured_next = 1'b0;
            update = 1'b1;
            shown  = check;
            if (in_range(stepped, cfg.temp_low, cfg.temp_high)) begin
              shown = stepped;
              if (st.target_is_max) begin
                st_next.max_setpoint = stepped;
                save = SAVE_MAX;
              end else begin
                st_next.normal_setpoint = stepped;
                save = SAVE_NORMAL;
              end
            end
          end
          default: begin
          end
        endcase
      end
      MODE_LOAD: begin
        st_next.normal_setpoint =
          in_range(item.stored_normal, cfg.temp_low, cfg.temp_high) ?
          item.stored_normal : cfg.default_normal;
        st_next.max_setpoint =
          in_range(item.stored_max, cfg.temp_low, cfg.temp_high) ?
          item.stored_max : cfg.default_max;
        st_next.power_full    = (item.stored_power == STORED_POWER_FULL);
        st_next.target_is_max = (item.stored_target == STORED_TARGET_MAX);
      end
      default: begin
      end
    endcase
  end

  // divide by ten: exact for values below 1029
  assign tens_prod = {8'd0, shown} * 16'd205;
  assign tens      = 5'(tens_prod >> 11);
  assign tens_x10  = 8'({3'd0, tens} * 8'd10);

  always_comb begin
    res.heater_drive = st_next.heater_cmd;
    res.warm_led     = st_next.warm_lamp;
    res.led_normal   = !st_next.target_is_max;
    res.led_max      = st_next.target_is_max;
    res.led_full     = st_next.power_full;
    res.error_code   = err;
    res.show_update  = update;
    res.digit_tens   = update ? tens : '0;
    res.digit_ones   = update ? 4'(shown - tens_x10) : '0;
    res.save_request = save;
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import thc_pkg::*;

  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam logic [2:0] BTN_NONE       = 3'd0;
  localparam logic [2:0] BTN_UNUSED_MIN = 3'd5;
  localparam logic [2:0] BTN_UNUSED_MAX = 3'd7;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 210;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 4;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] button;
    logic [7:0] measured;
    logic       present;
    logic [7:0] s_norm;
    logic [7:0] s_max;
    logic [7:0] s_pow;
    logic [7:0] s_tgt;
  } evt_t;

  typedef struct packed {
    logic    pinned;
    result_t want;
  } pin_t;

  typedef struct packed {
    evt_t    ev;
    logic    pinned;
    result_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  thermostat_hysteresis_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // shadow of the thermostat
  cfg_t       cfg;
  logic [7:0] sp_normal;
  logic [7:0] sp_max;
  logic       tgt_max;
  logic       pwr_full;
  logic [1:0] heat;
  logic       lamp;
  logic       show_meas;

  result_t panel_expect_q[$];
  pin_t    pinned_q[$];
  row_t    rows[$];
  int      mismatches;
  int      beats_in;
  int      cycles;
  logic    rx_holding;

  evt_t    mon_ev;
  result_t mon_want;
  result_t mon_got;
  pin_t    mon_pin;

  function automatic logic fits_band(input logic [7:0] v);
    return (v >= cfg.temp_low) && (v <= cfg.temp_high);
  endfunction

  task automatic advance_thermostat(input evt_t e, output result_t r);
    logic [7:0] check;
    logic [7:0] reading;
    logic [7:0] nv;
    logic [7:0] shown;
    logic       upd;
    int         lim;
    r = '0;
    upd = 1'b0;
    shown = '0;
    case (e.kind)
      MODE_SAMPLE: begin
        check = tgt_max ? sp_max : sp_normal;
        reading = e.present ? e.measured : 8'd0;
        lim = int'(check) - int'(cfg.hysteresis);
        if (!e.present) begin
          heat = HEAT_OFF;
          r.error_code = ERR_MISSING;
        end else if (!fits_band(reading)) begin
          heat = HEAT_OFF;
          r.error_code = ERR_RANGE;
        end else if (int'(reading) <= lim) begin
          heat = pwr_full ? HEAT_FULL : HEAT_HALF;
          lamp = 1'b1;
        end else if (reading >= check) begin
          heat = HEAT_OFF;
          lamp = 1'b0;
        end
        upd = 1'b1;
        shown = show_meas ? reading : check;
        show_meas = !show_meas;
      end
      MODE_BUTTON: begin
        case (e.button)
          BTN_POWER: begin
            pwr_full = !pwr_full;
            r.save_request = SAVE_POWER;
          end
          BTN_TARGET: begin
            tgt_max = !tgt_max;
            show_meas = 1'b0;
            upd = 1'b1;
            shown = tgt_max ? sp_max : sp_normal;
            r.save_request = SAVE_TARGET;
          end
          BTN_PLUS, BTN_MINUS: begin
            nv = tgt_max ? sp_max : sp_normal;
            nv = (e.button == BTN_PLUS) ? nv + 8'd1 : nv - 8'd1;
            if (fits_band(nv)) begin
              if (tgt_max) sp_max = nv;
              else sp_normal = nv;
              r.save_request = tgt_max ? SAVE_MAX : SAVE_NORMAL;
            end
            show_meas = 1'b0;
            upd = 1'b1;
            shown = tgt_max ? sp_max : sp_normal;
          end
          default: ;
        endcase
      end
      MODE_LOAD: begin
        sp_normal = fits_band(e.s_norm) ? e.s_norm : cfg.default_normal;
        sp_max = fits_band(e.s_max) ? e.s_max : cfg.default_max;
        pwr_full = (e.s_pow == STORED_POWER_FULL);
        tgt_max = (e.s_tgt == STORED_TARGET_MAX);
      end
      default: ;
    endcase
    r.heater_drive = heat;
    r.warm_led = lamp;
    r.led_normal = !tgt_max;
    r.led_max = tgt_max;
    r.led_full = pwr_full;
    r.show_update = upd;
    r.digit_tens = upd ? 5'(shown / 8'd10) : 5'd0;
    r.digit_ones = upd ? 4'(shown % 8'd10) : 4'd0;
  endtask

  task automatic check_field(input string name, input int w, input int g);
    if (w != g) begin
      mismatches++;
      $display("%0t %s expected %0d got %0d", $time, name, w, g);
    end
  endtask

  function automatic evt_t mk_evt(input logic [1:0] kind, input logic [2:0] button,
                                  input logic [7:0] measured, input logic present,
                                  input logic [7:0] n, input logic [7:0] m,
                                  input logic [7:0] p, input logic [7:0] t);
    evt_t e;
    e.kind = kind;
    e.button = button;
    e.measured = measured;
    e.present = present;
    e.s_norm = n;
    e.s_max = m;
    e.s_pow = p;
    e.s_tgt = t;
    return e;
  endfunction

  task automatic put_row(input evt_t e, input logic pin, input result_t w);
    row_t rw;
    rw.ev = e;
    rw.pinned = pin;
    rw.want = w;
    rows.push_back(rw);
  endtask

  task automatic send_event(input evt_t e, input logic pin, input result_t w);
    pin_t p;
    p.pinned = pin;
    p.want = w;
    pinned_q.push_back(p);
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, e.s_tgt, e.s_pow, e.s_max, e.s_norm, e.present, e.measured, e.button};
    s_tuser <= e.kind;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (panel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_settings(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_addr <= REG_TEMP_LOW;
    cfg_wdata <= c.temp_low;
    @(posedge clk);
    cfg_addr <= REG_TEMP_HIGH;
    cfg_wdata <= c.temp_high;
    @(posedge clk);
    cfg_addr <= REG_HYSTERESIS;
    cfg_wdata <= c.hysteresis;
    @(posedge clk);
    cfg_addr <= REG_DEFAULT_NORMAL;
    cfg_wdata <= c.default_normal;
    @(posedge clk);
    cfg_addr <= REG_DEFAULT_MAX;
    cfg_wdata <= c.default_max;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // input beat -> expectation, output beat -> compare
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        mon_ev.kind = s_tuser;
        mon_ev.button = s_tdata[2:0];
        mon_ev.measured = s_tdata[10:3];
        mon_ev.present = s_tdata[11];
        mon_ev.s_norm = s_tdata[19:12];
        mon_ev.s_max = s_tdata[27:20];
        mon_ev.s_pow = s_tdata[35:28];
        mon_ev.s_tgt = s_tdata[43:36];
        advance_thermostat(mon_ev, mon_want);
        mon_pin = pinned_q.pop_front();
        panel_expect_q.push_back(mon_pin.pinned ? mon_pin.want : mon_want);
        beats_in++;
      end
      if (m_tvalid && m_tready) begin
        if (panel_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result beat: expected none got %h", $time, m_tdata);
        end else begin
          mon_want = panel_expect_q.pop_front();
          mon_got.heater_drive = m_tdata[1:0];
          mon_got.warm_led = m_tdata[2];
          mon_got.led_normal = m_tdata[3];
          mon_got.led_max = m_tdata[4];
          mon_got.led_full = m_tdata[5];
          mon_got.error_code = m_tdata[7:6];
          mon_got.show_update = m_tdata[8];
          mon_got.digit_tens = m_tdata[13:9];
          mon_got.digit_ones = m_tdata[17:14];
          mon_got.save_request = m_tdata[20:18];
          check_field("heater_drive", int'(mon_want.heater_drive),
                      int'(mon_got.heater_drive));
          check_field("warm_led", int'(mon_want.warm_led), int'(mon_got.warm_led));
          check_field("led_normal", int'(mon_want.led_normal), int'(mon_got.led_normal));
          check_field("led_max", int'(mon_want.led_max), int'(mon_got.led_max));
          check_field("led_full", int'(mon_want.led_full), int'(mon_got.led_full));
          check_field("error_code", int'(mon_want.error_code), int'(mon_got.error_code));
          check_field("show_update", int'(mon_want.show_update),
                      int'(mon_got.show_update));
          check_field("digit_tens", int'(mon_want.digit_tens), int'(mon_got.digit_tens));
          check_field("digit_ones", int'(mon_want.digit_ones), int'(mon_got.digit_ones));
          check_field("save_request", int'(mon_want.save_request),
                      int'(mon_got.save_request));
        end
      end
    end
  end

  // result side: short and long stalls, one long hold to back up the input
  initial begin
    int r;
    logic held;
    held = 1'b0;
    rx_holding = 1'b0;
    m_tready <= 1'b0;
    forever begin
      if (!held && beats_in >= 500) begin
        held = 1'b1;
        rx_holding = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_holding = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (r < 95) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    cfg_t    plan[PHASES];
    evt_t    ev;
    result_t none;
    int      useful;
    int      gap;
    int      burst_left;
    int      r;
    int      b;
    int      tmp;
    logic [7:0] near;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cycles = 0;
    mismatches = 0;
    beats_in = 0;
    burst_left = 0;
    none = '0;

    cfg = '{RST_TEMP_LOW, RST_TEMP_HIGH, RST_HYSTERESIS, RST_DEFAULT_NORMAL,
            RST_DEFAULT_MAX};
    sp_normal = RST_DEFAULT_NORMAL;
    sp_max = RST_DEFAULT_MAX;
    tgt_max = 1'b0;
    pwr_full = 1'b0;
    heat = HEAT_OFF;
    lamp = 1'b0;
    show_meas = 1'b1;

    plan[0] = cfg;
    plan[1] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
    plan[2] = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    plan[3] = '{8'd20, 8'd30, 8'd255, 8'd25, 8'd60};
    plan[4] = '{8'd50, 8'd50, 8'd1, 8'd50, 8'd50};
    for (int i = 5; i < PHASES; i++) begin
      plan[i].temp_low = 8'($urandom_range(0, 120));
      plan[i].temp_high = 8'($urandom_range(100, 255));
      plan[i].hysteresis = 8'($urandom_range(0, 40));
      plan[i].default_normal = 8'($urandom);
      plan[i].default_max = 8'($urandom);
    end

    // reset defaults: normal 25, max 60, band 5..95, hysteresis 2
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd20, 1'b1, 0, 0, 0, 0), 1'b1,
            '{HEAT_HALF, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b1, 5'd2, 4'd0, SAVE_NONE});
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd255, 1'b0, 0, 0, 0, 0), 1'b1,
            '{HEAT_OFF, 1'b1, 1'b1, 1'b0, 1'b0, ERR_MISSING, 1'b1, 5'd2, 4'd5, SAVE_NONE});
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd255, 1'b1, 0, 0, 0, 0), 1'b1,
            '{HEAT_OFF, 1'b1, 1'b1, 1'b0, 1'b0, ERR_RANGE, 1'b1, 5'd25, 4'd5, SAVE_NONE});
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd0, 1'b1, 0, 0, 0, 0), 1'b1,
            '{HEAT_OFF, 1'b1, 1'b1, 1'b0, 1'b0, ERR_RANGE, 1'b1, 5'd2, 4'd5, SAVE_NONE});
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd5, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd95, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_POWER, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd10, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_TARGET, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_PLUS, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_MINUS, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_NONE, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_UNUSED_MAX, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_SPARE, BTN_UNUSED_MAX, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255,
                   8'd255), 1'b0, none);
    put_row(mk_evt(MODE_LOAD, BTN_NONE, 8'd0, 1'b0, 8'd30, 8'd70, STORED_POWER_FULL,
                   STORED_TARGET_MAX), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd70, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_LOAD, BTN_NONE, 8'd0, 1'b0, 8'd4, 8'd96, 8'd3, 8'd2), 1'b0, none);
    put_row(mk_evt(MODE_LOAD, BTN_NONE, 8'd0, 1'b0, 8'd255, 8'd0, 8'd0, 8'd0), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd23, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_SAMPLE, BTN_NONE, 8'd24, 1'b1, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_BUTTON, BTN_UNUSED_MIN, 8'd0, 1'b0, 0, 0, 0, 0), 1'b0, none);
    put_row(mk_evt(MODE_LOAD, BTN_UNUSED_MAX, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255,
                   8'd255), 1'b0, none);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if ($urandom_range(0, 2) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      send_event(rows[i].ev, rows[i].pinned, rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph != 0) write_settings(plan[ph]);
      useful = 0;
      while (useful < PER_PHASE) begin
        ev.button = 3'($urandom);
        ev.measured = 8'($urandom);
        ev.present = 1'($urandom);
        ev.s_norm = 8'($urandom);
        ev.s_max = 8'($urandom);
        ev.s_pow = 8'($urandom);
        ev.s_tgt = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50) begin
          ev.kind = MODE_SAMPLE;
          ev.present = ($urandom_range(0, 19) != 0);
          if ($urandom_range(0, 1) == 1) begin
            near = tgt_max ? sp_max : sp_normal;
            tmp = int'(near) - int'(cfg.hysteresis) - 2
                  + int'($urandom_range(0, int'(cfg.hysteresis) + 4));
            ev.measured = tmp[7:0];
          end
        end else if (r < 82) begin
          ev.kind = MODE_BUTTON;
          b = $urandom_range(0, 9);
          if (b < 4) ev.button = BTN_PLUS;
          else if (b < 7) ev.button = BTN_MINUS;
          else if (b == 7) ev.button = BTN_POWER;
          else if (b == 8) ev.button = BTN_TARGET;
        end else if (r < 92) begin
          ev.kind = MODE_LOAD;
          if ($urandom_range(0, 1) == 1) begin
            if (cfg.temp_low <= cfg.temp_high) begin
              ev.s_norm = 8'($urandom_range(cfg.temp_low, cfg.temp_high));
              ev.s_max = 8'($urandom_range(cfg.temp_low, cfg.temp_high));
            end
            ev.s_pow = 8'($urandom_range(1, 2));
            ev.s_tgt = 8'($urandom_range(0, 1));
          end
        end else begin
          ev.kind = 2'($urandom);
        end
        if (!(ev.kind == MODE_SPARE ||
              (ev.kind == MODE_BUTTON && (ev.button == BTN_NONE ||
                                          ev.button >= BTN_UNUSED_MIN))))
          useful++;

        if (rx_holding || burst_left > 0) begin
          gap = 0;
          if (burst_left > 0) burst_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
          end else if (r < 40) gap = 0;
          else if (r < 92) gap = $urandom_range(1, 3);
          else gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        send_event(ev, 1'b0, none);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
